>>> rtl/core/bpr_sgd_update_defines.svh
// Assertion macros used by the checker file of the ranking update block.
`ifndef BPR_SGD_UPDATE_DEFINES_SVH
`define BPR_SGD_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define BSGD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsgd check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define BSGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsgd check failed");

`endif

>>> rtl/core/bsgd_pkg.sv
// Shared constants, types and arithmetic helpers of the ranking update block.
package bsgd_pkg;

  localparam int FEATURES_DEF      = 10;
  localparam int USER_ENTRIES_DEF  = 1024;
  localparam int PHOTO_ENTRIES_DEF = 1024;
  localparam int POST_ENTRIES_DEF  = 1024;
  localparam int VALUE_WIDTH_DEF   = 32;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRAIN = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] TBL_USER  = 2'd0;
  localparam logic [1:0] TBL_PHOTO = 2'd1;
  localparam logic [1:0] TBL_POST  = 2'd2;

  localparam logic KIND_POST = 1'b1;

  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_REG_WEIGHT = 1'b1;

  localparam logic [15:0] LEARN_RATE_RST = 16'd655;
  localparam logic [15:0] REG_WEIGHT_RST = 16'd0;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // 65536/(1+e^x) for x = 0, 0.5, ..., 8
  localparam logic [15:0] W_TAB [17] = '{
    16'd32768, 16'd24743, 16'd17625, 16'd11955, 16'd7812, 16'd4971, 16'd3108,
    16'd1921, 16'd1179, 16'd720, 16'd439, 16'd267, 16'd162, 16'd98, 16'd60,
    16'd36, 16'd22
  };

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic  start;
    logic  frac;
    wide_t a;
    wide_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    wide_t prod;
  } mul_rsp_t;

  // Saturating 64-bit add
  function automatic wide_t sadd(input wide_t a, input wide_t b);
    wide_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // Saturating 64-bit subtract
  function automatic wide_t ssub(input wide_t a, input wide_t b);
    wide_t d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) begin
      d = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return d;
  endfunction

  // 1 - sigmoid from the table, t holds |x| in Q3.16
  function automatic logic [15:0] weight(input logic neg, input logic big,
                                         input logic [18:0] t);
    logic [3:0]  idx;
    logic [14:0] fr;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] span;
    logic [30:0] step;
    logic [16:0] w;
    idx  = t[18:15];
    fr   = t[14:0];
    hi   = W_TAB[idx];
    lo   = W_TAB[5'(idx) + 5'd1];
    span = hi - lo;
    step = 31'(span) * 31'(fr);
    w    = big ? 17'(W_TAB[16]) : 17'(hi) - 17'(step[30:15]);
    if (neg) begin
      w = 17'd65536 - w;
      if (w > 17'd65535) begin
        w = 17'd65535;
      end
    end
    return w[15:0];
  endfunction

endpackage

>>> rtl/core/bsgd_req_if.sv
// Command channel of the ranking update block.
interface bsgd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  table_select;
  logic [9:0]  entry_index;
  logic [3:0]  element_index;
  logic signed [31:0] element_value;
  logic        item_kind;
  logic [9:0]  item_index;
  logic [9:0]  user_index;
  logic [9:0]  neg_item_index;
  logic [9:0]  neg_user_index;

  modport source (output valid, command, table_select, entry_index, element_index,
                  element_value, item_kind, item_index, user_index, neg_item_index,
                  neg_user_index, input ready);
  modport sink (input valid, command, table_select, entry_index, element_index,
                element_value, item_kind, item_index, user_index, neg_item_index,
                neg_user_index, output ready);
endinterface

>>> rtl/core/bsgd_rsp_if.sv
// Result channel of the ranking update block.
interface bsgd_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic signed [31:0] read_value;
  logic [15:0] item_side_weight;
  logic [15:0] user_side_weight;

  modport source (output valid, status, read_value, item_side_weight,
                  user_side_weight, input ready);
  modport sink (input valid, status, read_value, item_side_weight,
                user_side_weight, output ready);
endinterface

>>> rtl/core/bsgd_cfg_if.sv
// Register write channel of the ranking update block.
interface bsgd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/bpr_sgd_update.sv
// Ranking update block: user, photo and post latent vectors in on-chip RAM with
// element write and read commands and a pairwise ranking training step. One command
// is in flight at a time; req.ready is high only while idle. A write goes through
// the address and access states to the result; a read adds a wait for the RAM. A
// train step walks the FEATURES elements twice: first reading the four vectors and
// forming three dot products, then re-reading them to apply the regularized steps
// and write back item and user together, then negative item and negative user. All
// products go through one shared multiplier, fifteen per element, and the sequencer
// waits for each product to finish before it issues the next one.
// No clearing pass runs after reset; vectors must be written before they are read.
// Results saturate to the element width.
module bpr_sgd_update #(
  parameter int FEATURES      = bsgd_pkg::FEATURES_DEF,
  parameter int USER_ENTRIES  = bsgd_pkg::USER_ENTRIES_DEF,
  parameter int PHOTO_ENTRIES = bsgd_pkg::PHOTO_ENTRIES_DEF,
  parameter int POST_ENTRIES  = bsgd_pkg::POST_ENTRIES_DEF,
  parameter int VALUE_WIDTH   = bsgd_pkg::VALUE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bsgd_req_if.sink  req,
  bsgd_rsp_if.source rsp,
  bsgd_cfg_if.sink  cfg
);

  localparam int FRAC   = VALUE_WIDTH - 4;
  localparam int KW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int UAW    = $clog2(USER_ENTRIES * FEATURES);
  localparam int PHAW   = $clog2(PHOTO_ENTRIES * FEATURES);
  localparam int POAW   = $clog2(POST_ENTRIES * FEATURES);
  localparam int MAW0   = (UAW > PHAW) ? UAW : PHAW;
  localparam int MAW1   = (MAW0 > POAW) ? MAW0 : POAW;
  localparam int MAW    = (MAW1 > 0) ? MAW1 : 1;
  localparam int SHR    = (FRAC >= 16) ? FRAC - 16 : 0;
  localparam int SHL    = (FRAC >= 16) ? 0 : 16 - FRAC;

  // dot-product pass
  localparam logic [3:0] OP_POS      = 4'd0;
  localparam logic [3:0] OP_NEG_ITEM = 4'd1;
  localparam logic [3:0] OP_NEG_USER = 4'd2;
  // update pass
  localparam logic [3:0] OP_REG_I    = 4'd0;
  localparam logic [3:0] OP_REG_U    = 4'd1;
  localparam logic [3:0] OP_E2_DU    = 4'd2;
  localparam logic [3:0] OP_E1_U     = 4'd3;
  localparam logic [3:0] OP_E2_I     = 4'd4;
  localparam logic [3:0] OP_E1_DI    = 4'd5;
  localparam logic [3:0] OP_REG_NI   = 4'd6;
  localparam logic [3:0] OP_REG_NU   = 4'd7;
  localparam logic [3:0] OP_STEP_I   = 4'd8;
  localparam logic [3:0] OP_STEP_U   = 4'd9;
  localparam logic [3:0] OP_STEP_NI  = 4'd10;
  localparam logic [3:0] OP_STEP_NU  = 4'd11;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_ADDR  = 11'b00000000010,
    ST_ACC   = 11'b00000000100,
    ST_RWAIT = 11'b00000001000,
    ST_RD    = 11'b00000010000,
    ST_MUL   = 11'b00000100000,
    ST_DIFF  = 11'b00001000000,
    ST_WGT   = 11'b00010000000,
    ST_GRAD  = 11'b00100000000,
    ST_WR    = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  // latched command
  logic [1:0]  cmd;
  logic [1:0]  tsel;
  logic [9:0]  ent;
  logic [3:0]  el;
  logic signed [31:0] wval;
  logic        kind;
  logic [9:0]  ii;
  logic [9:0]  ui;
  logic [9:0]  ni;
  logic [9:0]  nu;
  logic [MAW-1:0] addr;
  logic [MAW-1:0] base_i;
  logic [MAW-1:0] base_u;
  logic [MAW-1:0] base_ni;
  logic [MAW-1:0] base_nu;

  // sequencer
  logic [KW-1:0] k;
  logic [1:0]    sub;
  logic [3:0]    op;
  logic          dot;
  logic          issued;

  // datapath registers
  bsgd_pkg::wide_t vi, vu, vni, vnu;
  bsgd_pkg::wide_t acc_pos, acc_n1, acc_n2;
  bsgd_pkg::wide_t d1, d2;
  bsgd_pkg::wide_t gi, gu, gni, gnu;
  bsgd_pkg::wide_t prod [12];
  logic [15:0] e1, e2;
  logic [15:0] learn_rate;
  logic [15:0] reg_weight;

  bsgd_pkg::mul_req_t mreq;
  bsgd_pkg::mul_rsp_t mrsp;

  // memory side
  logic           we_user, we_photo, we_post;
  logic [MAW-1:0] waddr_item, waddr_user, raddr_item, raddr_user;
  logic [VALUE_WIDTH-1:0] wdata_item, wdata_user;
  logic [VALUE_WIDTH-1:0] rd_user, rd_photo, rd_post, rd_item, rd_sel;
  logic [MAW-1:0] item_addr, user_addr;
  logic [VALUE_WIDTH-1:0] new_i, new_u, new_ni, new_nu, wr_val;

  // misc combinational
  logic        bad;
  logic [31:0] item_entries;
  logic [31:0] sel_entries;
  bsgd_pkg::wide_t ext_wval;

  // saturate a 64-bit value to the element width
  function automatic logic [VALUE_WIDTH-1:0] satv(input bsgd_pkg::wide_t v);
    logic ov;
    logic [VALUE_WIDTH-1:0] r;
    ov = (v[63:VALUE_WIDTH-1] != {(65 - VALUE_WIDTH){v[63]}});
    if (ov) begin
      r = v[63] ? {1'b1, {(VALUE_WIDTH - 1){1'b0}}} : {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    end else begin
      r = v[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

  // weight from a score difference
  function automatic logic [15:0] diff_weight(input bsgd_pkg::wide_t d);
    logic [63:0] m;
    logic [63:0] t;
    logic        big;
    m   = d[63] ? 64'd0 - 64'(d) : 64'(d);
    big = m >= (64'd8 << FRAC);
    t   = (m >> SHR) << SHL;
    return bsgd_pkg::weight(d[63], big, t[18:0]);
  endfunction

  // register port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= bsgd_pkg::LEARN_RATE_RST;
      reg_weight <= bsgd_pkg::REG_WEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        bsgd_pkg::REG_LEARN_RATE: learn_rate <= cfg.data;
        bsgd_pkg::REG_REG_WEIGHT: reg_weight <= cfg.data;
        default: ;
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_OUT);

  // range checks on the latched command
  assign item_entries = (kind == bsgd_pkg::KIND_POST) ? 32'(POST_ENTRIES)
                                                      : 32'(PHOTO_ENTRIES);
  always_comb begin
    case (tsel)
      bsgd_pkg::TBL_USER:  sel_entries = 32'(USER_ENTRIES);
      bsgd_pkg::TBL_PHOTO: sel_entries = 32'(PHOTO_ENTRIES);
      bsgd_pkg::TBL_POST:  sel_entries = 32'(POST_ENTRIES);
      default:             sel_entries = 32'd0;
    endcase
  end

  always_comb begin
    case (cmd)
      bsgd_pkg::CMD_WRITE, bsgd_pkg::CMD_READ:
        bad = (32'(ent) >= sel_entries) || (32'(el) >= 32'(FEATURES));
      bsgd_pkg::CMD_TRAIN:
        bad = (32'(ii) >= item_entries) || (32'(ni) >= item_entries) ||
              (32'(ui) >= 32'(USER_ENTRIES)) || (32'(nu) >= 32'(USER_ENTRIES));
      default:
        bad = 1'b1;
    endcase
  end

  // element addresses of the current pass
  assign item_addr = ((sub == 2'd0) ? base_i : base_ni) + MAW'(k);
  assign user_addr = ((sub == 2'd0) ? base_u : base_nu) + MAW'(k);

  assign rd_item  = (kind == bsgd_pkg::KIND_POST) ? rd_post : rd_photo;
  assign ext_wval = bsgd_pkg::wide_t'(wval);
  assign wr_val   = satv(ext_wval);

  assign new_i  = satv(bsgd_pkg::sadd(vi, prod[OP_STEP_I]));
  assign new_u  = satv(bsgd_pkg::sadd(vu, prod[OP_STEP_U]));
  assign new_ni = satv(bsgd_pkg::sadd(vni, prod[OP_STEP_NI]));
  assign new_nu = satv(bsgd_pkg::sadd(vnu, prod[OP_STEP_NU]));

  always_comb begin
    case (tsel)
      bsgd_pkg::TBL_USER:  rd_sel = rd_user;
      bsgd_pkg::TBL_PHOTO: rd_sel = rd_photo;
      default:             rd_sel = rd_post;
    endcase
  end

  // memory control
  always_comb begin
    we_user    = 1'b0;
    we_photo   = 1'b0;
    we_post    = 1'b0;
    waddr_item = item_addr;
    waddr_user = user_addr;
    raddr_item = item_addr;
    raddr_user = user_addr;
    wdata_item = (sub == 2'd0) ? new_i : new_ni;
    wdata_user = (sub == 2'd0) ? new_u : new_nu;
    case (state)
      ST_ACC: begin
        waddr_item = addr;
        waddr_user = addr;
        raddr_item = addr;
        raddr_user = addr;
        wdata_item = wr_val;
        wdata_user = wr_val;
        if (cmd == bsgd_pkg::CMD_WRITE) begin
          case (tsel)
            bsgd_pkg::TBL_USER:  we_user  = 1'b1;
            bsgd_pkg::TBL_PHOTO: we_photo = 1'b1;
            bsgd_pkg::TBL_POST:  we_post  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_WR: begin
        we_user  = 1'b1;
        we_post  = (kind == bsgd_pkg::KIND_POST);
        we_photo = (kind != bsgd_pkg::KIND_POST);
      end
      default: ;
    endcase
  end

  bsgd_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(USER_ENTRIES * FEATURES)) u_user_ram (
    .clk   (clk),
    .we    (we_user),
    .waddr (waddr_user[UAW-1:0]),
    .wdata (wdata_user),
    .raddr (raddr_user[UAW-1:0]),
    .rdata (rd_user)
  );

  bsgd_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(PHOTO_ENTRIES * FEATURES)) u_photo_ram (
    .clk   (clk),
    .we    (we_photo),
    .waddr (waddr_item[PHAW-1:0]),
    .wdata (wdata_item),
    .raddr (raddr_item[PHAW-1:0]),
    .rdata (rd_photo)
  );

  bsgd_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POST_ENTRIES * FEATURES)) u_post_ram (
    .clk   (clk),
    .we    (we_post),
    .waddr (waddr_item[POAW-1:0]),
    .wdata (wdata_item),
    .raddr (raddr_item[POAW-1:0]),
    .rdata (rd_post)
  );

  // multiplier operand select
  always_comb begin
    mreq.start = (state == ST_MUL) && !issued;
    mreq.frac  = dot;
    mreq.a     = vi;
    mreq.b     = vu;
    if (dot) begin
      case (op)
        OP_POS:      begin mreq.a = vi;  mreq.b = vu;  end
        OP_NEG_ITEM: begin mreq.a = vni; mreq.b = vu;  end
        default:     begin mreq.a = vi;  mreq.b = vnu; end
      endcase
    end else begin
      case (op)
        OP_REG_I:   begin mreq.a = 64'(reg_weight); mreq.b = vi; end
        OP_REG_U:   begin mreq.a = 64'(reg_weight); mreq.b = vu; end
        OP_E2_DU:   begin mreq.a = 64'(e2); mreq.b = bsgd_pkg::ssub(vu, vnu); end
        OP_E1_U:    begin mreq.a = 64'(e1); mreq.b = vu; end
        OP_E2_I:    begin mreq.a = 64'(e2); mreq.b = vi; end
        OP_E1_DI:   begin mreq.a = 64'(e1); mreq.b = bsgd_pkg::ssub(vi, vni); end
        OP_REG_NI:  begin mreq.a = 64'(reg_weight); mreq.b = vni; end
        OP_REG_NU:  begin mreq.a = 64'(reg_weight); mreq.b = vnu; end
        OP_STEP_I:  begin mreq.a = 64'(learn_rate); mreq.b = gi; end
        OP_STEP_U:  begin mreq.a = 64'(learn_rate); mreq.b = gu; end
        OP_STEP_NI: begin mreq.a = 64'(learn_rate); mreq.b = gni; end
        default:    begin mreq.a = 64'(learn_rate); mreq.b = gnu; end
      endcase
    end
  end

  bsgd_mul #(.FRAC(FRAC)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
      k      <= '0;
      sub    <= '0;
      op     <= '0;
      dot    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          k   <= '0;
          sub <= '0;
          op  <= '0;
          dot <= 1'b1;
          if (bad) begin
            state <= ST_OUT;
          end else if (cmd == bsgd_pkg::CMD_TRAIN) begin
            state <= ST_RD;
          end else begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          state <= (cmd == bsgd_pkg::CMD_READ) ? ST_RWAIT : ST_OUT;
        end
        ST_RWAIT: state <= ST_OUT;
        ST_RD: begin
          if (sub == 2'd2) begin
            sub   <= '0;
            op    <= '0;
            state <= ST_MUL;
          end else begin
            sub <= sub + 2'd1;
          end
        end
        ST_MUL: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (mrsp.done) begin
            issued <= 1'b0;
            if (dot) begin
              if (op == OP_NEG_USER) begin
                op <= '0;
                if (k == KW'(FEATURES - 1)) begin
                  state <= ST_DIFF;
                end else begin
                  k     <= k + KW'(1);
                  state <= ST_RD;
                end
              end else begin
                op <= op + 4'd1;
              end
            end else if (op == OP_REG_NU) begin
              op    <= OP_STEP_I;
              state <= ST_GRAD;
            end else if (op == OP_STEP_NU) begin
              sub   <= '0;
              state <= ST_WR;
            end else begin
              op <= op + 4'd1;
            end
          end
        end
        ST_DIFF: state <= ST_WGT;
        ST_WGT: begin
          dot   <= 1'b0;
          k     <= '0;
          sub   <= '0;
          state <= ST_RD;
        end
        ST_GRAD: state <= ST_MUL;
        ST_WR: begin
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else begin
            sub <= '0;
            op  <= '0;
            if (k == KW'(FEATURES - 1)) begin
              state <= ST_OUT;
            end else begin
              k     <= k + KW'(1);
              state <= ST_RD;
            end
          end
        end
        ST_OUT: begin
          if (rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cmd     <= req.command;
          tsel    <= req.table_select;
          ent     <= req.entry_index;
          el      <= req.element_index;
          wval    <= req.element_value;
          kind    <= req.item_kind;
          ii      <= req.item_index;
          ui      <= req.user_index;
          ni      <= req.neg_item_index;
          nu      <= req.neg_user_index;
          addr    <= MAW'(req.entry_index) * MAW'(FEATURES) + MAW'(req.element_index);
          base_i  <= MAW'(req.item_index) * MAW'(FEATURES);
          base_u  <= MAW'(req.user_index) * MAW'(FEATURES);
          base_ni <= MAW'(req.neg_item_index) * MAW'(FEATURES);
          base_nu <= MAW'(req.neg_user_index) * MAW'(FEATURES);
        end
      end
      ST_ADDR: begin
        acc_pos              <= '0;
        acc_n1               <= '0;
        acc_n2               <= '0;
        rsp.status           <= bad ? bsgd_pkg::STATUS_BAD : bsgd_pkg::STATUS_OK;
        rsp.read_value       <= '0;
        rsp.item_side_weight <= '0;
        rsp.user_side_weight <= '0;
      end
      ST_RWAIT: begin
        rsp.read_value <= 32'(bsgd_pkg::wide_t'(signed'(rd_sel)));
      end
      ST_RD: begin
        if (sub == 2'd1) begin
          vi <= bsgd_pkg::wide_t'(signed'(rd_item));
          vu <= bsgd_pkg::wide_t'(signed'(rd_user));
        end else if (sub == 2'd2) begin
          vni <= bsgd_pkg::wide_t'(signed'(rd_item));
          vnu <= bsgd_pkg::wide_t'(signed'(rd_user));
        end
      end
      ST_MUL: begin
        if (issued && mrsp.done) begin
          if (dot) begin
            case (op)
              OP_POS:      acc_pos <= bsgd_pkg::sadd(acc_pos, mrsp.prod);
              OP_NEG_ITEM: acc_n1  <= bsgd_pkg::sadd(acc_n1, mrsp.prod);
              default:     acc_n2  <= bsgd_pkg::sadd(acc_n2, mrsp.prod);
            endcase
          end else begin
            prod[op] <= mrsp.prod;
          end
        end
      end
      ST_DIFF: begin
        d1 <= bsgd_pkg::ssub(acc_pos, acc_n1);
        d2 <= bsgd_pkg::ssub(acc_pos, acc_n2);
      end
      ST_WGT: begin
        e1                   <= diff_weight(d1);
        e2                   <= diff_weight(d2);
        rsp.item_side_weight <= diff_weight(d1);
        rsp.user_side_weight <= diff_weight(d2);
      end
      ST_GRAD: begin
        gi  <= bsgd_pkg::sadd(bsgd_pkg::ssub(prod[OP_E2_DU], prod[OP_REG_I]),
                              bsgd_pkg::ssub(prod[OP_E1_U], prod[OP_REG_I]));
        gu  <= bsgd_pkg::sadd(bsgd_pkg::ssub(prod[OP_E2_I], prod[OP_REG_U]),
                              bsgd_pkg::ssub(prod[OP_E1_DI], prod[OP_REG_U]));
        gni <= bsgd_pkg::ssub(bsgd_pkg::ssub('0, prod[OP_E1_U]), prod[OP_REG_NI]);
        gnu <= bsgd_pkg::ssub(bsgd_pkg::ssub('0, prod[OP_E2_I]), prod[OP_REG_NU]);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/bsgd_ram.sv
// Generic simple dual-port RAM with registered read.
module bsgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bsgd_mul.sv
// Shared signed multiplier: 64x64 from four 32x32 partial products, shift, saturate.
module bsgd_mul #(
  parameter int FRAC = bsgd_pkg::VALUE_WIDTH_DEF - 4
) (
  input  logic               clk,
  input  logic               rst,
  input  bsgd_pkg::mul_req_t req,
  output bsgd_pkg::mul_rsp_t rsp
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic         frac;
  logic [63:0]  pp;
  logic [1:0]   ppsh;
  logic [127:0] acc;
  logic [127:0] pp_wide;
  logic [127:0] shifted;
  logic [63:0]  q;
  logic         over;
  logic [31:0]  ah;
  logic [31:0]  bh;
  logic         done_q;
  bsgd_pkg::wide_t prod_q;

  assign ah = cnt[1] ? ua[63:32] : ua[31:0];
  assign bh = cnt[0] ? ub[63:32] : ub[31:0];

  // place the last partial product at its weight
  always_comb begin
    case (ppsh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
  end

  // truncate toward zero, flag overflow of the signed 64-bit range
  assign shifted = frac ? (acc >> FRAC) : (acc >> 16);
  assign q       = shifted[63:0];
  assign over    = |shifted[127:63];

  assign rsp = '{done: done_q, prod: prod_q};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitudes in, one partial product a cycle, then sign and saturate
  always_ff @(posedge clk) begin
    if (req.start) begin
      ua   <= req.a[63] ? 64'd0 - 64'(req.a) : 64'(req.a);
      ub   <= req.b[63] ? 64'd0 - 64'(req.b) : 64'(req.b);
      neg  <= req.a[63] ^ req.b[63];
      frac <= req.frac;
      acc  <= '0;
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        pp   <= 64'(ah) * 64'(bh);
        ppsh <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_wide;
      end
      if (cnt == 3'd5) begin
        if (neg) begin
          prod_q <= over ? {1'b1, 63'd0} : bsgd_pkg::wide_t'(64'd0 - q);
        end else begin
          prod_q <= over ? {1'b0, {63{1'b1}}} : bsgd_pkg::wide_t'(q);
        end
      end
    end
  end

endmodule

>>> rtl/core/bsgd_checker.sv
// Port-level checks of the ranking update block, bound to the top level.
`include "bpr_sgd_update_defines.svh"

module bsgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_status,
  input logic [31:0] rsp_read_value,
  input logic [15:0] rsp_item_side_weight,
  input logic [15:0] rsp_user_side_weight
);

  // one command at a time: no new beat while a result waits
  `BSGD_ASSERT(a_no_overlap, rsp_valid, !req_ready)
  // busy right after taking a command
  `BSGD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready && !rsp_valid)
  // a rejected command reports nothing else
  `BSGD_ASSERT(a_reject_clean, rsp_valid && rsp_status, rsp_read_value == 32'd0 && rsp_item_side_weight == 16'd0 && rsp_user_side_weight == 16'd0)
  // a stalled result beat stays valid and keeps its read value
  `BSGD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value))

endmodule

bind bpr_sgd_update bsgd_checker u_bsgd_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_status           (rsp.status),
  .rsp_read_value       (rsp.read_value),
  .rsp_item_side_weight (rsp.item_side_weight),
  .rsp_user_side_weight (rsp.user_side_weight)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the pairwise ranking update block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bsgd_pkg::*;

  localparam int NFEAT     = FEATURES_DEF;
  localparam int TBL_DEPTH = 1024 * NFEAT;
  localparam int CYCLE_CAP = 6000000;
  localparam int RAND_PER_PHASE = 260;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] TBL_NONE    = 2'd3;
  localparam wide_t WIDE_MAX = {1'b0, {63{1'b1}}};
  localparam wide_t WIDE_MIN = {1'b1, 63'd0};

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         table_select;
    logic [9:0]         entry_index;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic               item_kind;
    logic [9:0]         item_index;
    logic [9:0]         user_index;
    logic [9:0]         neg_item_index;
    logic [9:0]         neg_user_index;
  } cmd_beat_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] read_value;
    logic [15:0]        item_side_weight;
    logic [15:0]        user_side_weight;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsgd_req_if req ();
  bsgd_rsp_if rsp ();
  bsgd_cfg_if cfg ();

  bpr_sgd_update DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive state: held command beat, valid, ready and register port
  cmd_beat_t   cur_beat = '0;
  logic        cmd_valid = 1'b0;
  logic        rsp_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = REG_LEARN_RATE;
  logic [15:0] cfg_data = '0;

  assign req.valid          = cmd_valid;
  assign req.command        = cur_beat.command;
  assign req.table_select   = cur_beat.table_select;
  assign req.entry_index    = cur_beat.entry_index;
  assign req.element_index  = cur_beat.element_index;
  assign req.element_value  = cur_beat.element_value;
  assign req.item_kind      = cur_beat.item_kind;
  assign req.item_index     = cur_beat.item_index;
  assign req.user_index     = cur_beat.user_index;
  assign req.neg_item_index = cur_beat.neg_item_index;
  assign req.neg_user_index = cur_beat.neg_user_index;
  assign rsp.ready          = rsp_ready;
  assign cfg.valid          = cfg_valid;
  assign cfg.index          = cfg_index;
  assign cfg.data           = cfg_data;

  cmd_beat_t pending_cmds[$];
  rsp_beat_t rsp_expect[$];
  int        issued_cnt = 0;
  int        accepted_cnt = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  logic      calm = 1'b0;
  int        written_addr[$];

  // Shadow of the vector tables and registers
  wide_t       vec_mem [0:2][0:TBL_DEPTH-1];
  logic [15:0] shadow_lr = LEARN_RATE_RST;
  logic [15:0] shadow_rw = REG_WEIGHT_RST;

  function automatic wide_t add_sat(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd0 && s[64] != s[63]) return WIDE_MAX;
    if (s[64] != s[63]) return s[64] ? WIDE_MIN : WIDE_MAX;
    return s[63:0];
  endfunction

  function automatic wide_t sub_sat(wide_t a, wide_t b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? WIDE_MIN : WIDE_MAX;
    return d[63:0];
  endfunction

  // Exact product scaled by 2^-sh, truncated toward zero, saturated
  function automatic wide_t mul_fix(wide_t a, wide_t b, int sh);
    logic [63:0]  ua, ub;
    logic [127:0] q;
    ua = a[63] ? 64'd0 - a : a;
    ub = b[63] ? 64'd0 - b : b;
    q  = ({64'd0, ua} * {64'd0, ub}) >> sh;
    if (a[63] != b[63]) begin
      if (q >= (128'd1 << 63)) return WIDE_MIN;
      return 64'd0 - q[63:0];
    end
    if (q > 128'(WIDE_MAX)) return WIDE_MAX;
    return q[63:0];
  endfunction

  function automatic wide_t clamp_elem(wide_t v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic wide_t dot_fix(wide_t x [NFEAT], wide_t y [NFEAT]);
    wide_t acc;
    acc = 0;
    for (int k = 0; k < NFEAT; k++) acc = add_sat(acc, mul_fix(x[k], y[k], 28));
    return acc;
  endfunction

  // 1 - sigmoid by table lookup with linear interpolation
  function automatic wide_t rank_weight(wide_t diff);
    logic [63:0] m, t, w;
    int          idx;
    m = diff[63] ? 64'd0 - diff : diff;
    if (m >= (64'd8 << 28)) begin
      w = W_TAB[16];
    end else begin
      t   = m >> 12;
      idx = int'((t >> 15) & 64'd15);
      w   = W_TAB[idx] - (((W_TAB[idx] - W_TAB[idx+1]) * (t & 64'h7FFF)) >> 15);
    end
    if (diff[63]) begin
      w = 65536 - w;
      if (w > 65535) w = 65535;
    end
    return w;
  endfunction

  // Apply one accepted command to the shadow and queue its result
  function automatic void predict_update(cmd_beat_t b);
    rsp_beat_t r;
    int        it, base, ui, ni, nu;
    wide_t     vi [NFEAT], vu [NFEAT], vni [NFEAT], vnu [NFEAT];
    wide_t     e1, e2, rw, lr, li, lu, gi, gu, gni, gnu, pos;
    r = '0;
    r.status = STATUS_BAD;
    if (b.command == CMD_WRITE || b.command == CMD_READ) begin
      if (b.table_select != TBL_NONE && b.element_index < NFEAT) begin
        base = b.entry_index * NFEAT + b.element_index;
        if (b.command == CMD_WRITE)
          vec_mem[b.table_select][base] = clamp_elem(wide_t'(b.element_value));
        else
          r.read_value = vec_mem[b.table_select][base][31:0];
        r.status = STATUS_OK;
      end
    end else if (b.command == CMD_TRAIN) begin
      it = b.item_kind ? TBL_POST : TBL_PHOTO;
      base = b.item_index * NFEAT;
      ui = b.user_index * NFEAT;
      ni = b.neg_item_index * NFEAT;
      nu = b.neg_user_index * NFEAT;
      for (int k = 0; k < NFEAT; k++) begin
        vi[k]  = vec_mem[it][base+k];
        vu[k]  = vec_mem[TBL_USER][ui+k];
        vni[k] = vec_mem[it][ni+k];
        vnu[k] = vec_mem[TBL_USER][nu+k];
      end
      pos = dot_fix(vi, vu);
      e1  = rank_weight(sub_sat(pos, dot_fix(vni, vu)));
      e2  = rank_weight(sub_sat(pos, dot_fix(vi, vnu)));
      rw  = shadow_rw;
      lr  = shadow_lr;
      // Gradients from the old vectors; write back item, user, neg item, neg user
      for (int k = 0; k < NFEAT; k++) begin
        li  = mul_fix(rw, vi[k], 16);
        lu  = mul_fix(rw, vu[k], 16);
        gi  = add_sat(sub_sat(mul_fix(e2, sub_sat(vu[k], vnu[k]), 16), li),
                      sub_sat(mul_fix(e1, vu[k], 16), li));
        gu  = add_sat(sub_sat(mul_fix(e2, vi[k], 16), lu),
                      sub_sat(mul_fix(e1, sub_sat(vi[k], vni[k]), 16), lu));
        gni = sub_sat(sub_sat(0, mul_fix(e1, vu[k], 16)), mul_fix(rw, vni[k], 16));
        gnu = sub_sat(sub_sat(0, mul_fix(e2, vi[k], 16)), mul_fix(rw, vnu[k], 16));
        vec_mem[it][base+k]     = clamp_elem(add_sat(vi[k], mul_fix(lr, gi, 16)));
        vec_mem[TBL_USER][ui+k] = clamp_elem(add_sat(vu[k], mul_fix(lr, gu, 16)));
        vec_mem[it][ni+k]       = clamp_elem(add_sat(vni[k], mul_fix(lr, gni, 16)));
        vec_mem[TBL_USER][nu+k] = clamp_elem(add_sat(vnu[k], mul_fix(lr, gnu, 16)));
      end
      r.status = STATUS_OK;
      r.item_side_weight = e1[15:0];
      r.user_side_weight = e2[15:0];
    end
    rsp_expect.insert(rsp_expect.size(), r);
  endfunction

  // Driver: advance to the next pending beat once the held one is taken
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      gap <= 0;
    end else begin
      if (cmd_valid && req.ready) begin
        predict_update(cur_beat);
        accepted_cnt++;
      end
      if (!cmd_valid || req.ready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_beat <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 17);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, stall in random bursts
  int stall = 0;
  always @(posedge clk) begin
    rsp_beat_t e;
    if (rst) begin
      rsp_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (rsp.valid && rsp_ready) begin
        if (rsp_expect.size() == 0) begin
          $display("%0t: unexpected result beat status %0d", $time, rsp.status);
          err_cnt++;
        end else begin
          e = rsp_expect.pop_front();
          if (rsp.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
            err_cnt++;
          end
          if (rsp.read_value !== e.read_value) begin
            $display("%0t: read_value exp %h got %h", $time, e.read_value, rsp.read_value);
            err_cnt++;
          end
          if (rsp.item_side_weight !== e.item_side_weight) begin
            $display("%0t: item_side_weight exp %0d got %0d", $time,
                     e.item_side_weight, rsp.item_side_weight);
            err_cnt++;
          end
          if (rsp.user_side_weight !== e.user_side_weight) begin
            $display("%0t: user_side_weight exp %0d got %0d", $time,
                     e.user_side_weight, rsp.user_side_weight);
            err_cnt++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall <= $urandom_range(0, 16);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic cmd_beat_t junk_beat();
    cmd_beat_t b;
    b = ($bits(cmd_beat_t))'({$urandom, $urandom, $urandom});
    return b;
  endfunction

  function automatic void queue_access(logic [1:0] cmd, logic [1:0] tsel, int ent, int el,
                                       logic signed [31:0] val);
    cmd_beat_t b;
    b = junk_beat();
    b.command = cmd;
    b.table_select = tsel;
    b.entry_index = 10'(ent);
    b.element_index = 4'(el);
    b.element_value = val;
    if (cmd == CMD_WRITE && tsel != TBL_NONE && el < NFEAT)
      written_addr.insert(written_addr.size(), tsel * TBL_DEPTH + ent * NFEAT + el);
    pending_cmds.insert(pending_cmds.size(), b);
    issued_cnt++;
  endfunction

  function automatic void queue_train(logic kind, int ii, int ui, int ni, int nu);
    cmd_beat_t b;
    b = junk_beat();
    b.command = CMD_TRAIN;
    b.item_kind = kind;
    b.item_index = 10'(ii);
    b.user_index = 10'(ui);
    b.neg_item_index = 10'(ni);
    b.neg_user_index = 10'(nu);
    pending_cmds.insert(pending_cmds.size(), b);
    issued_cnt++;
  endfunction

  function automatic logic signed [31:0] mild_value();
    return $urandom_range(0, 1 << 29) - (1 << 28);
  endfunction

  task automatic cfg_send(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_LEARN_RATE) shadow_lr = data;
    else shadow_rw = data;
  endtask

  task automatic settle();
    wait (accepted_cnt == issued_cnt && rsp_expect.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  int pool [4] = '{0, 1, 2, 1023};

  initial begin
    int sel, a;
    logic [15:0] lr_set [5];
    logic [15:0] rw_set [5];
    lr_set = '{LEARN_RATE_RST, 16'd0, 16'hFFFF, 16'd0, 16'd655};
    rw_set = '{REG_WEIGHT_RST, 16'd0, 16'hFFFF, 16'd0, 16'd655};
    lr_set[3] = 16'($urandom_range(1, 4000));
    rw_set[3] = 16'($urandom_range(1, 4000));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        cfg_send(REG_LEARN_RATE, lr_set[p]);
        cfg_send(REG_REG_WEIGHT, rw_set[p]);
        @(posedge clk);
        cfg_valid <= 1'b0;
      end
      if (p == 4) calm = 1'b1;
      if (p == 0) begin
        // Load every vector that a train step may touch
        for (int t = 0; t < 3; t++)
          foreach (pool[j])
            for (int k = 0; k < NFEAT; k++)
              queue_access(CMD_WRITE, 2'(t), pool[j], k, mild_value());
        // Extremes, bad addresses, unknown command, aliased train steps
        queue_access(CMD_WRITE, TBL_USER, 0, 0, 32'sh7FFF_FFFF);
        queue_access(CMD_READ, TBL_USER, 0, 0, 0);
        queue_access(CMD_WRITE, TBL_PHOTO, 1, 9, -32'sh8000_0000);
        queue_access(CMD_READ, TBL_PHOTO, 1, 9, 0);
        queue_access(CMD_WRITE, TBL_POST, 1023, 5, 0);
        queue_access(CMD_READ, TBL_POST, 1023, 5, 0);
        queue_access(CMD_WRITE, TBL_NONE, 3, 2, 32'sh1234_5678);
        queue_access(CMD_READ, TBL_NONE, 1023, 0, 0);
        queue_access(CMD_WRITE, TBL_USER, 2, 10, 32'sh0100_0000);
        queue_access(CMD_READ, TBL_POST, 0, 15, 0);
        queue_access(CMD_UNKNOWN, TBL_USER, 0, 0, 0);
        queue_train(1'b0, 0, 0, 1, 1);
        queue_train(1'b1, 1023, 2, 1023, 2);
        queue_train(1'b0, 1023, 1023, 0, 2);
        queue_train(1'b0, 1, 0, 2, 1023);
        queue_access(CMD_READ, TBL_USER, 0, 0, 0);
        queue_access(CMD_WRITE, TBL_USER, 0, 0, mild_value());
        queue_access(CMD_WRITE, TBL_PHOTO, 1, 9, mild_value());
        queue_train(1'b1, 0, 1, 2, 0);
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          queue_train(1'($urandom_range(0, 1)), pool[$urandom_range(0, 3)],
                      pool[$urandom_range(0, 3)], pool[$urandom_range(0, 3)],
                      pool[$urandom_range(0, 3)]);
        end else if (sel < 45) begin
          queue_access(CMD_WRITE, 2'($urandom_range(0, 2)), pool[$urandom_range(0, 3)],
                       $urandom_range(0, NFEAT - 1), mild_value());
        end else if (sel < 80) begin
          a = written_addr[$urandom_range(0, written_addr.size() - 1)];
          queue_access(CMD_READ, 2'(a / TBL_DEPTH), (a % TBL_DEPTH) / NFEAT, a % NFEAT, 0);
        end else if (sel < 88) begin
          queue_access(CMD_WRITE, 2'($urandom_range(0, 2)), $urandom_range(0, 1023),
                       $urandom_range(0, NFEAT - 1), $urandom);
        end else if (sel < 92) begin
          queue_access(CMD_WRITE, 2'($urandom_range(0, 2)), pool[$urandom_range(0, 3)],
                       $urandom_range(0, NFEAT - 1), $urandom);
        end else begin
          // Rejected: unknown command, no table, or element past the vector
          case ($urandom_range(0, 2))
            0: queue_access(CMD_UNKNOWN, 2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                            $urandom_range(0, 15), $urandom);
            1: queue_access($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, TBL_NONE,
                            $urandom_range(0, 1023), $urandom_range(0, 15), $urandom);
            default: queue_access($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                                  2'($urandom_range(0, 2)), $urandom_range(0, 1023),
                                  $urandom_range(NFEAT, 15), $urandom);
          endcase
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bsgd_pkg.sv
rtl/core/bsgd_req_if.sv
rtl/core/bsgd_rsp_if.sv
rtl/core/bsgd_cfg_if.sv
rtl/core/bsgd_ram.sv
rtl/core/bsgd_mul.sv
rtl/core/bpr_sgd_update.sv
rtl/core/bsgd_checker.sv
tb/sv/tb_top.sv
